@@ sv/assert_macros.svh @@
// Assertion macros shared by the deque RTL.
// Every macro samples on clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dq_pkg.sv @@
// Package for the double-ended queue: sizes, request and status codes,
// pointer helper functions and the control structs. No dependencies.
package dq_pkg;

  localparam int DEPTH   = 32;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;

  localparam int REQ_W   = 3;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 6;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DROP_HEAD  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DROP_TAIL  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READOUT    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_COUNT      = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // pointer update request from the sequencer
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic drop_head;
    logic drop_tail;
  } ptr_cmd_t;

  // pointer state seen by the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
  } ptr_stat_t;

  // (base + off) mod DEPTH, valid while base < DEPTH and off <= DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

endpackage

@@ sv/dq_ifs.sv @@
// Handshake channels of the deque: request beats in, result beats out.
// Depends on dq_pkg for the field widths.
interface dq_req_if;
  logic                            valid;
  logic                            ready;
  logic [dq_pkg::REQ_W-1:0]        req_type;
  logic signed [dq_pkg::VAL_W-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

interface dq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [dq_pkg::STAT_W-1:0]       status;
  logic signed [dq_pkg::VAL_W-1:0] data;
  logic [dq_pkg::OCNT_W-1:0]       count;
  logic                            last;

  modport source (output valid, status, data, count, last, input ready);
  modport sink   (input valid, status, data, count, last, output ready);
endinterface

@@ sv/dq_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/dq_ptr.sv @@
// Head pointer and fill count of the ring store, plus write/read slot math.
// Depends on dq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dq_ptr (
  input  logic                     clk,
  input  logic                     rst,
  input  dq_pkg::ptr_cmd_t         cmd,
  input  logic [dq_pkg::PTR_W-1:0] rd_off,
  output dq_pkg::ptr_stat_t        stat,
  output logic [dq_pkg::PTR_W-1:0] wr_addr,
  output logic [dq_pkg::PTR_W-1:0] rd_addr
);

  logic [dq_pkg::PTR_W-1:0] front, front_next;
  logic [dq_pkg::CNT_W-1:0] count, count_next;

  // next pointer state; an emptied store puts the head back at slot zero
  always_comb begin
    front_next = front;
    count_next = count;
    if (cmd.push_front) begin
      front_next = dq_pkg::wrap_dec(front);
      count_next = count + dq_pkg::CNT_W'(1);
    end else if (cmd.push_back) begin
      count_next = count + dq_pkg::CNT_W'(1);
    end else if (cmd.drop_head) begin
      front_next = dq_pkg::wrap_inc(front);
      count_next = count - dq_pkg::CNT_W'(1);
    end else if (cmd.drop_tail) begin
      count_next = count - dq_pkg::CNT_W'(1);
    end
    if (count_next == '0) front_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

  // slot addresses: new head goes one below front, new tail at front + count
  assign wr_addr = cmd.push_front ? dq_pkg::wrap_dec(front)
                                  : dq_pkg::wrap_add(front, count);
  assign rd_addr = dq_pkg::wrap_add(front, dq_pkg::CNT_W'(rd_off));

  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count >= dq_pkg::CNT_W'(dq_pkg::DEPTH));

  `ASSERT_ALWAYS(a_count_bound, count <= dq_pkg::CNT_W'(dq_pkg::DEPTH), "count above depth")
  `ASSERT_ALWAYS(a_empty_front, (count != '0) || (front == '0), "empty store with head off zero")
  `ASSERT_ALWAYS(a_one_cmd, $onehot0(cmd), "more than one pointer command")
  `ASSERT_NEXT(a_push_grows, (cmd.push_front || cmd.push_back) && !stat.full,
               count == $past(count) + dq_pkg::CNT_W'(1), "push did not grow count")

endmodule

@@ sv/double_ended_queue_top.sv @@
// Double-ended queue of 32-bit values in a ring RAM with head pointer and count.
// Push, drop, count requests: result registered at accept, 1 per cycle unless stalled.
// Readout of N entries: first beat via RAM read and result registers, then 1 per cycle
// while the sink keeps up; requests are held off until the final beat is loaded.
// Reset (synchronous, rst high) clears head, count and result valid; RAM contents stay
// undefined and need no clearing pass.
`include "assert_macros.svh"

module double_ended_queue_top (
  input  logic            clk,
  input  logic            rst,
  dq_req_if.sink          req,
  dq_rsp_if.source        rsp
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                    state, state_next;
  logic [dq_pkg::PTR_W-1:0]  rd_idx, rd_idx_next;
  logic                      valid_next;
  logic [dq_pkg::STAT_W-1:0] status_next;
  logic [dq_pkg::VAL_W-1:0]  data_next;
  logic [dq_pkg::OCNT_W-1:0] count_next;
  logic                      last_next;

  dq_pkg::ptr_cmd_t          cmd;
  dq_pkg::ptr_stat_t         stat;
  logic [dq_pkg::PTR_W-1:0]  wr_addr, rd_addr;
  logic                      wr_en;
  logic [dq_pkg::VAL_W-1:0]  rd_data;
  logic [dq_pkg::CNT_W-1:0]  cnt_after;
  logic                      out_free, accept, final_beat;

  // pointer unit and entry store
  dq_ptr u_ptr (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .rd_off (rd_idx_next),
    .stat   (stat),
    .wr_addr(wr_addr),
    .rd_addr(rd_addr)
  );

  dq_ram #(.WIDTH(dq_pkg::VAL_W), .DEPTH(dq_pkg::DEPTH)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(req.value),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // output register frees when empty or drained this cycle
  assign out_free   = !rsp.valid || rsp.ready;
  assign req.ready  = (state == S_IDLE) && out_free;
  assign accept     = req.valid && req.ready;
  assign final_beat = (dq_pkg::CNT_W'(rd_idx) == stat.count - dq_pkg::CNT_W'(1));

  // request decode and readout sequencing; writes only happen in idle, so a
  // readout never sees a write to the slot it is reading
  always_comb begin
    state_next  = state;
    rd_idx_next = rd_idx;
    cmd         = '0;
    wr_en       = 1'b0;
    cnt_after   = stat.count;
    valid_next  = rsp.valid && !rsp.ready;
    status_next = rsp.status;
    data_next   = rsp.data;
    count_next  = rsp.count;
    last_next   = rsp.last;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          valid_next  = 1'b1;
          status_next = dq_pkg::ST_OK;
          data_next   = '0;
          last_next   = 1'b1;
          unique case (req.req_type) inside
            dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
              if (stat.full) begin
                status_next = dq_pkg::ST_FULL;
              end else begin
                cmd.push_front = (req.req_type == dq_pkg::REQ_PUSH_FRONT);
                cmd.push_back  = (req.req_type == dq_pkg::REQ_PUSH_BACK);
                wr_en          = 1'b1;
                cnt_after      = stat.count + dq_pkg::CNT_W'(1);
              end
            end
            dq_pkg::REQ_DROP_HEAD, dq_pkg::REQ_DROP_TAIL: begin
              if (stat.empty) begin
                status_next = dq_pkg::ST_EMPTY;
              end else begin
                cmd.drop_head = (req.req_type == dq_pkg::REQ_DROP_HEAD);
                cmd.drop_tail = (req.req_type == dq_pkg::REQ_DROP_TAIL);
                cnt_after     = stat.count - dq_pkg::CNT_W'(1);
              end
            end
            dq_pkg::REQ_READOUT: begin
              if (stat.empty) begin
                status_next = dq_pkg::ST_EMPTY;
              end else begin
                // head read issued now, first beat loads from the RAM output in S_READ
                valid_next  = 1'b0;
                rd_idx_next = '0;
                state_next  = S_READ;
              end
            end
            default: begin
            end
          endcase
          count_next = dq_pkg::OCNT_W'(cnt_after);
        end
      end
      S_READ: begin
        // a stalled beat re-reads the same slot, so the RAM output holds
        if (out_free) begin
          valid_next  = 1'b1;
          status_next = dq_pkg::ST_OK;
          data_next   = rd_data;
          count_next  = dq_pkg::OCNT_W'(stat.count);
          last_next   = final_beat;
          if (final_beat) begin
            state_next = S_IDLE;
          end else begin
            rd_idx_next = rd_idx + dq_pkg::PTR_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_idx    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_idx    <= rd_idx_next;
      rsp.valid <= valid_next;
    end
    rsp.status <= status_next;
    rsp.data   <= data_next;
    rsp.count  <= count_next;
    rsp.last   <= last_next;
  end

  `ASSERT_ALWAYS(a_read_blocks, (state != S_READ) || !req.ready, "request taken during readout")
  `ASSERT_ALWAYS(a_idx_in_range, (state != S_READ) || (dq_pkg::CNT_W'(rd_idx) < stat.count),
                 "readout index past tail")
  `ASSERT_NEXT(a_read_count_hold, state == S_READ, stat.count == $past(stat.count),
               "count changed during readout")

endmodule

@@ bench/double_ended_queue_top_test.sv @@
// Self-checking bench for double_ended_queue_top: random bursty requests, a stalling
// result sink and a ring-store predictor of the expected result beats.
// Depends on dq_pkg, the dq_req_if / dq_rsp_if channels and the deque RTL.
module double_ended_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  // codes the block treats as no-ops
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 250;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 150;

  typedef struct {
    logic [REQ_W-1:0]        kind;
    logic signed [VAL_W-1:0] val;
  } deque_req_t;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] data;
    logic [OCNT_W-1:0]       count;
    logic                    last;
  } deque_beat_t;

  typedef enum int {FILL_UP, DRAIN_DOWN, MIXED, NOISE} mix_t;
  typedef enum int {PACE_STEADY, PACE_PATTERN, PACE_RANDOM} pace_t;

  logic clk;
  logic rst;

  dq_req_if req_ch ();
  dq_rsp_if rsp_ch ();

  double_ended_queue_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // stimulus backlog and expected result beats
  deque_req_t  req_backlog[$];
  deque_beat_t beats_due[$];

  // predictor copy of the ring store
  logic signed [VAL_W-1:0] ring_slot[DEPTH];
  int unsigned             head_slot;
  int unsigned             held;

  int mismatches;

  // driver state
  deque_req_t next_req;
  int         burst_left;
  int         gap_left;

  // receiver state
  int          beats_taken;
  int          hold_left;
  bit          hold_done;
  pace_t       pace_mode;
  int          pace_left;
  logic [31:0] stall_pattern;

  // monitor scratch
  deque_beat_t due;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_COUNT;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Queue the beats one accepted request should produce and advance the ring.
  function automatic void forecast_beats(input logic [REQ_W-1:0] kind,
                                         input logic signed [VAL_W-1:0] val);
    deque_beat_t b;
    b.status = ST_OK;
    b.data   = '0;
    b.last   = 1'b1;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (held >= DEPTH) begin
          b.status = ST_FULL;
        end else begin
          if (kind == REQ_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            ring_slot[head_slot] = val;
          end else begin
            ring_slot[(head_slot + held) % DEPTH] = val;
          end
          held++;
        end
      end
      REQ_DROP_HEAD, REQ_DROP_TAIL: begin
        if (held == 0) begin
          b.status = ST_EMPTY;
        end else begin
          if (kind == REQ_DROP_HEAD) head_slot = (head_slot + 1) % DEPTH;
          held--;
          // an emptied store restarts at slot zero
          if (held == 0) head_slot = 0;
        end
      end
      REQ_READOUT: begin
        if (held == 0) begin
          b.status = ST_EMPTY;
        end else begin
          for (int unsigned i = 0; i < held; i++) begin
            b.data  = ring_slot[(head_slot + i) % DEPTH];
            b.count = OCNT_W'(held);
            b.last  = (i + 1 == held);
            beats_due.push_back(b);
          end
          return;
        end
      end
      default: ;
    endcase
    b.count = OCNT_W'(held);
    beats_due.push_back(b);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_kind(input mix_t mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      FILL_UP: begin
        if (r < 85) return r[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        if (r < 90) return REQ_READOUT;
        if (r < 95) return REQ_COUNT;
        return r[0] ? REQ_DROP_TAIL : REQ_DROP_HEAD;
      end
      DRAIN_DOWN: begin
        if (r < 85) return r[0] ? REQ_DROP_TAIL : REQ_DROP_HEAD;
        if (r < 92) return REQ_READOUT;
        if (r < 96) return REQ_COUNT;
        return r[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      end
      MIXED: begin
        return REQ_W'($urandom_range(0, 5));
      end
      default: begin
        return REQ_W'($urandom_range(0, 7));
      end
    endcase
  endfunction

  task automatic add_req(input logic [REQ_W-1:0] kind, input logic signed [VAL_W-1:0] val);
    deque_req_t r;
    r.kind = kind;
    r.val  = val;
    req_backlog.push_back(r);
  endtask

  // Stimulus, then drain and verdict
  initial begin
    int   seg_left;
    mix_t mix;
    int   step;

    mismatches = 0;
    head_slot  = 0;
    held       = 0;

    // directed: empty-store errors, extremes at both ends, no-op codes, emptying
    add_req(REQ_READOUT,    '0);
    add_req(REQ_DROP_HEAD,  '0);
    add_req(REQ_DROP_TAIL,  '0);
    add_req(REQ_COUNT,      '0);
    add_req(REQ_PUSH_BACK,  32'sh7fff_ffff);
    add_req(REQ_PUSH_FRONT, 32'sh8000_0000);
    add_req(REQ_PUSH_BACK,  '0);
    add_req(REQ_PUSH_FRONT, -32'sd1);
    add_req(REQ_READOUT,    '0);
    add_req(REQ_SPARE_6,    32'sh1234_5678);
    add_req(REQ_SPARE_7,    -32'sd1);
    add_req(REQ_DROP_HEAD,  '0);
    add_req(REQ_DROP_TAIL,  '0);
    add_req(REQ_COUNT,      -32'sd1);
    add_req(REQ_READOUT,    '0);
    add_req(REQ_DROP_HEAD,  '0);
    add_req(REQ_DROP_TAIL,  '0);
    add_req(REQ_READOUT,    '0);
    add_req(REQ_PUSH_FRONT, 32'sh5555_5555);
    add_req(REQ_PUSH_BACK,  32'shaaaa_aaaa);
    add_req(REQ_READOUT,    '0);
    add_req(REQ_DROP_TAIL,  '0);
    add_req(REQ_DROP_HEAD,  '0);
    add_req(REQ_DROP_HEAD,  '0);

    // random: segments that fill to full, drain to empty, mix and add noise
    step = 0;
    seg_left = 0;
    mix = FILL_UP;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        case (step % 5)
          0, 3:    mix = FILL_UP;
          1, 4:    mix = DRAIN_DOWN;
          default: mix = ($urandom_range(0, 2) == 0) ? NOISE : MIXED;
        endcase
        step++;
        seg_left = (mix == FILL_UP || mix == DRAIN_DOWN) ? $urandom_range(42, 55)
                                                         : $urandom_range(20, 35);
      end
      seg_left--;
      add_req(pick_kind(mix), pick_value());
    end

    while (rst) @(posedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || beats_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Driver: bursts of request beats with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 16);
      gap_left   = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) forecast_beats(req_ch.req_type, req_ch.value);
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          next_req = req_backlog.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.req_type <= next_req.kind;
          req_ch.value    <= next_req.val;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: changing stall pace plus one long hold-off once traffic is flowing
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      beats_taken = 0;
      hold_left   = 0;
      hold_done   = 1'b0;
      pace_left   = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) beats_taken++;
      if (!hold_done && beats_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (pace_left == 0) begin
          pace_mode     = pace_t'($urandom_range(0, 2));
          pace_left     = $urandom_range(20, 80);
          stall_pattern = $urandom | 32'd1;
        end
        pace_left--;
        case (pace_mode)
          PACE_STEADY:  rsp_ch.ready <= 1'b1;
          PACE_PATTERN: rsp_ch.ready <= stall_pattern[pace_left % 32];
          default:      rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Monitor: each result beat against the oldest expected beat
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat status=%0d data=%0d count=%0d last=%0b",
                   $realtime, rsp_ch.status, rsp_ch.data, rsp_ch.count, rsp_ch.last);
      end else begin
        due = beats_due.pop_front();
        if (rsp_ch.status !== due.status || rsp_ch.data !== due.data ||
            rsp_ch.count !== due.count || rsp_ch.last !== due.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: beat wrong: got status=%0d data=%0d count=%0d last=%0b, %s",
                     $realtime, rsp_ch.status, rsp_ch.data, rsp_ch.count, rsp_ch.last,
                     $sformatf("want status=%0d data=%0d count=%0d last=%0b",
                               due.status, due.data, due.count, due.last));
        end
      end
    end
  end

endmodule
